// ----- rtl/pia_pkg.sv -----
package pia_pkg;

  localparam int unsigned SAMPLE_W  = 24;
  localparam int unsigned COUNT_W   = 16;
  localparam int unsigned FRAC_W    = 8;
  localparam int unsigned SAT_W     = 40;
  localparam int unsigned EVQ_DEPTH = 4;

  localparam logic [SAMPLE_W-1:0] MEAN_MAX  = '1;
  localparam logic [COUNT_W-1:0]  COUNT_MAX = '1;

  // Kind of event word passed from the peak finder to the interval accumulator.
  typedef struct packed {
    logic peak;
    logic last;
  } evt_flags_t;

  // Clamp a wide unsigned value to the mean_interval range.
  function automatic logic [SAMPLE_W-1:0] sat_mean(input logic [SAT_W-1:0] v);
    logic [SAMPLE_W-1:0] r;
    if (v > SAT_W'(MEAN_MAX)) begin
      r = MEAN_MAX;
    end else begin
      r = v[SAMPLE_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/pia_fifo.sv -----
module pia_fifo
  import pia_pkg::*;
#(
  parameter int unsigned WIDTH = 18,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [AW:0]      wr_q, rd_q;
  logic             do_push, do_pop;

  assign full_o  = (wr_q[AW] != rd_q[AW]) && (wr_q[AW-1:0] == rd_q[AW-1:0]);
  assign empty_o = (wr_q == rd_q);
  assign data_o  = slot_q[rd_q[AW-1:0]];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= rd_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q[AW-1:0]] <= data_i;
    end
  end

endmodule

// ----- rtl/pia_front.sv -----
module pia_front
  import pia_pkg::*;
#(
  parameter int unsigned MAX_SAMPLES    = 65535,
  parameter int unsigned NEIGHBOUR_SPAN = 2
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push_i,
  input  logic [SAMPLE_W-1:0]               amplitude_i,
  input  logic                              last_sample_i,
  input  logic [SAMPLE_W-1:0]               margin_i,
  output logic                              full_o,
  output logic                              evt_push_o,
  output evt_flags_t                        evt_flags_o,
  output logic [$clog2(MAX_SAMPLES)-1:0]    evt_idx_o,
  input  logic                              evt_full_i
);

  localparam int unsigned IW = $clog2(MAX_SAMPLES);
  localparam int unsigned WD = 2 * NEIGHBOUR_SPAN;
  localparam int unsigned DW = $clog2(NEIGHBOUR_SPAN + 1);
  localparam int unsigned EW = $clog2(WD + 1);
  localparam int unsigned CW = IW + 4;

  typedef enum logic [1:0] {
    FS_ACCEPT = 2'b01,
    FS_FLUSH  = 2'b10
  } fstate_e;

  fstate_e             state_q, state_d;
  logic [SAMPLE_W-1:0] window_q [WD];
  logic [SAMPLE_W-1:0] cur_q;
  logic [IW-1:0]       idx_q, idx_d;
  logic [DW-1:0]       off_q, off_d;

  logic [SAMPLE_W-1:0] ext [WD+1];
  logic [DW-1:0]       off;
  logic [SAMPLE_W-1:0] cand;
  logic [SAMPLE_W:0]   head;
  logic [EW-1:0]       lsel, rsel;
  logic                is_peak;
  logic                accept, at_end, judge_ok, flush_step, last_off;

  // Entry j of ext is the sample j places before the newest one.
  always_comb begin
    ext[0] = (state_q == FS_FLUSH) ? cur_q : amplitude_i;
    for (int j = 1; j <= WD; j++) begin
      ext[j] = window_q[j-1];
    end
  end

  // Judge the candidate off places back; a neighbour outside the sequence passes.
  always_comb begin
    off     = (state_q == FS_FLUSH) ? off_q : DW'(NEIGHBOUR_SPAN);
    cand    = ext[EW'(off)];
    head    = {1'b0, cand} - {1'b0, margin_i};
    is_peak = 1'b1;
    lsel    = '0;
    rsel    = '0;
    for (int k = 1; k <= NEIGHBOUR_SPAN; k++) begin
      lsel = EW'(off) + EW'(k);
      if ((CW'(off) + CW'(k) <= CW'(idx_q)) &&
          (head[SAMPLE_W] || (head[SAMPLE_W-1:0] <= ext[lsel]))) begin
        is_peak = 1'b0;
      end
      if (off >= DW'(k)) begin
        rsel = EW'(off) - EW'(k);
        if (head[SAMPLE_W] || (head[SAMPLE_W-1:0] <= ext[rsel])) begin
          is_peak = 1'b0;
        end
      end
    end
  end

  assign accept     = push_i && (state_q == FS_ACCEPT) && !evt_full_i;
  assign at_end     = last_sample_i || (idx_q == IW'(MAX_SAMPLES - 1));
  assign judge_ok   = CW'(idx_q) >= CW'(NEIGHBOUR_SPAN);
  assign flush_step = (state_q == FS_FLUSH) && !evt_full_i;
  assign last_off   = (off_q == '0);
  assign full_o     = (state_q != FS_ACCEPT) || evt_full_i;

  always_comb begin
    evt_push_o  = 1'b0;
    evt_flags_o = '{peak: is_peak, last: 1'b0};
    evt_idx_o   = idx_q - IW'(NEIGHBOUR_SPAN);
    state_d     = state_q;
    idx_d       = idx_q;
    off_d       = off_q;
    if (accept) begin
      evt_push_o = judge_ok && is_peak;
      if (at_end) begin
        off_d   = judge_ok ? DW'(NEIGHBOUR_SPAN - 1) : DW'(idx_q);
        state_d = FS_FLUSH;
      end else begin
        idx_d = idx_q + 1'b1;
      end
    end else if (flush_step) begin
      evt_push_o  = is_peak || last_off;
      evt_flags_o = '{peak: is_peak, last: last_off};
      evt_idx_o   = idx_q - IW'(off_q);
      if (last_off) begin
        idx_d   = '0;
        state_d = FS_ACCEPT;
      end else begin
        off_d = off_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FS_ACCEPT;
      idx_q   <= '0;
      off_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      off_q   <= off_d;
    end
  end

  // Hold the final sample for the flush; shift every other sample into the window.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (at_end) begin
        cur_q <= amplitude_i;
      end else begin
        window_q[0] <= amplitude_i;
        for (int j = 1; j < WD; j++) begin
          window_q[j] <= window_q[j-1];
        end
      end
    end
  end

endmodule

// ----- rtl/pia_div.sv -----
module pia_div
  import pia_pkg::*;
#(
  parameter int unsigned NW = 24,
  parameter int unsigned VW = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          done_o,
  output logic [NW-1:0] quotient_o
);

  localparam int unsigned CNTW = $clog2(NW + 1);

  logic            busy_q, done_q;
  logic [CNTW-1:0] cnt_q;
  logic [NW-1:0]   quo_q;
  logic [VW-1:0]   rem_q, dvs_q;
  logic [VW:0]     rem_sh;
  logic [VW+1:0]   diff;
  logic            ge;

  // One restoring step per cycle, quotient bits shift in from the bottom.
  assign rem_sh = {rem_q, quo_q[NW-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dvs_q};
  assign ge     = !diff[VW+1];

  assign done_o     = done_q;
  assign quotient_o = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNTW'(NW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[NW-2:0], ge};
      rem_q <= ge ? diff[VW-1:0] : rem_sh[VW-1:0];
    end
  end

endmodule

// ----- rtl/pia_back.sv -----
module pia_back
  import pia_pkg::*;
#(
  parameter int unsigned MAX_SAMPLES = 65535
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           evt_empty_i,
  input  evt_flags_t                     evt_flags_i,
  input  logic [$clog2(MAX_SAMPLES)-1:0] evt_idx_i,
  output logic                           evt_pop_o,
  output logic                           res_empty_o,
  input  logic                           res_pop_i,
  output logic [SAMPLE_W-1:0]            mean_o,
  output logic [COUNT_W-1:0]             count_o,
  output logic                           noint_o
);

  localparam int unsigned IW = $clog2(MAX_SAMPLES);
  localparam int unsigned QW = IW + FRAC_W;

  typedef enum logic [1:0] {
    BS_RUN = 2'b01,
    BS_DIV = 2'b10
  } bstate_e;

  bstate_e             state_q;
  logic [IW-1:0]       prev_q, sum_q, cnt_q;
  logic                seen_q;
  logic [COUNT_W-1:0]  total_q;
  logic                res_valid_q;
  logic [SAMPLE_W-1:0] res_mean_q;
  logic [COUNT_W-1:0]  res_count_q;
  logic                res_noint_q;

  logic [IW-1:0]       prev_n, sum_n, cnt_n, gap;
  logic                seen_n;
  logic [COUNT_W-1:0]  total_n;
  logic [IW:0]         samples;
  logic                take, finish, div_start, div_done;
  logic [QW-1:0]       quot;

  // Do not take the closing word while the previous result still waits.
  assign take      = (state_q == BS_RUN) && !evt_empty_i &&
                     !(evt_flags_i.last && res_valid_q);
  assign finish    = take && evt_flags_i.last;
  assign div_start = finish && (cnt_n != '0);
  assign evt_pop_o = take;
  assign gap       = evt_idx_i - prev_q;
  assign samples   = {1'b0, evt_idx_i} + 1'b1;

  always_comb begin
    prev_n  = prev_q;
    seen_n  = seen_q;
    sum_n   = sum_q;
    cnt_n   = cnt_q;
    total_n = total_q;
    if (evt_flags_i.peak) begin
      if (seen_q) begin
        sum_n = sum_q + gap;
        cnt_n = cnt_q + 1'b1;
      end
      prev_n  = evt_idx_i;
      seen_n  = 1'b1;
      total_n = (total_q == COUNT_MAX) ? total_q : total_q + 1'b1;
    end
  end

  pia_div #(
    .NW(QW),
    .VW(IW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i({sum_n, {FRAC_W{1'b0}}}),
    .divisor_i (cnt_n),
    .done_o    (div_done),
    .quotient_o(quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BS_RUN;
      prev_q      <= '0;
      seen_q      <= 1'b0;
      sum_q       <= '0;
      cnt_q       <= '0;
      total_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (res_pop_i && res_valid_q) begin
        res_valid_q <= 1'b0;
      end
      if (take) begin
        if (evt_flags_i.last) begin
          prev_q  <= '0;
          seen_q  <= 1'b0;
          sum_q   <= '0;
          cnt_q   <= '0;
          total_q <= '0;
          if (div_start) begin
            state_q <= BS_DIV;
          end else begin
            res_valid_q <= 1'b1;
          end
        end else begin
          prev_q  <= prev_n;
          seen_q  <= seen_n;
          sum_q   <= sum_n;
          cnt_q   <= cnt_n;
          total_q <= total_n;
        end
      end
      if ((state_q == BS_DIV) && div_done) begin
        res_valid_q <= 1'b1;
        state_q     <= BS_RUN;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      res_count_q <= total_n;
      res_noint_q <= !div_start;
      res_mean_q  <= sat_mean(SAT_W'({samples, {FRAC_W{1'b0}}}));
    end
    if ((state_q == BS_DIV) && div_done) begin
      res_mean_q <= sat_mean(SAT_W'(quot));
    end
  end

  assign res_empty_o = !res_valid_q;
  assign mean_o      = res_mean_q;
  assign count_o     = res_count_q;
  assign noint_o     = res_noint_q;

endmodule

// ----- rtl/peak_interval_averager_unit.sv -----
// Peak interval averager. Feed one amplitude word per packet through push/full
// and mark the final word of a sequence with last_sample_i. A sample is a peak
// when it exceeds every neighbour within NEIGHBOUR_SPAN places on either side
// by more than the margin register; neighbours beyond either end of the
// sequence pass. After the final word one result appears on the empty/pop side:
// the mean gap between consecutive peaks with 8 fractional bits (or the sample
// count with 8 fractional bits when fewer than two peaks were found, flagged by
// no_interval_o), and the saturating peak count. A sequence that reaches
// MAX_SAMPLES words ends at that word. Ordinary words are taken at one per
// cycle while the event queue has room. The final word holds the input side
// while the peak finder judges the trailing candidates, one per cycle while
// the event queue has room. The result word comes from a bit-serial divider,
// which starts when the averaging side takes the closing word; when there is
// no gap to average, the result appears in the next cycle instead. A
// four-word queue lets the next sequence start while that division runs.
// Write peak_margin only while the block is idle.
module peak_interval_averager_unit
  import pia_pkg::*;
#(
  parameter int unsigned MAX_SAMPLES    = 65535,
  parameter int unsigned NEIGHBOUR_SPAN = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic [SAMPLE_W-1:0] amplitude_i,
  input  logic                last_sample_i,
  output logic                empty,
  input  logic                pop,
  output logic [SAMPLE_W-1:0] mean_interval_o,
  output logic [COUNT_W-1:0]  peak_count_o,
  output logic                no_interval_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [SAMPLE_W-1:0] cfg_data_i
);

  localparam int unsigned IW = $clog2(MAX_SAMPLES);
  localparam int unsigned QDW = IW + $bits(evt_flags_t);

  logic [SAMPLE_W-1:0] margin_q;

  logic                fe_push;
  evt_flags_t          fe_flags;
  logic [IW-1:0]       fe_idx;
  logic                q_full, q_empty, q_pop;
  logic [QDW-1:0]      q_data;
  evt_flags_t          q_flags;
  logic [IW-1:0]       q_idx;

  // Margin register: always ready, writes are registered.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      margin_q <= '0;
    end else if (cfg_valid_i) begin
      margin_q <= cfg_data_i;
    end
  end

  // Front: window the samples and classify each candidate as peak or not.
  pia_front #(
    .MAX_SAMPLES   (MAX_SAMPLES),
    .NEIGHBOUR_SPAN(NEIGHBOUR_SPAN)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .amplitude_i  (amplitude_i),
    .last_sample_i(last_sample_i),
    .margin_i     (margin_q),
    .full_o       (full),
    .evt_push_o   (fe_push),
    .evt_flags_o  (fe_flags),
    .evt_idx_o    (fe_idx),
    .evt_full_i   (q_full)
  );

  // Decouple peak finding from averaging.
  pia_fifo #(
    .WIDTH(QDW),
    .DEPTH(EVQ_DEPTH)
  ) u_evq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (fe_push),
    .data_i ({fe_flags, fe_idx}),
    .full_o (q_full),
    .pop_i  (q_pop),
    .data_o (q_data),
    .empty_o(q_empty)
  );

  assign {q_flags, q_idx} = q_data;

  // Back: accumulate gaps, divide at most once per sequence, hold the result word.
  pia_back #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .evt_empty_i(q_empty),
    .evt_flags_i(q_flags),
    .evt_idx_i  (q_idx),
    .evt_pop_o  (q_pop),
    .res_empty_o(empty),
    .res_pop_i  (pop),
    .mean_o     (mean_interval_o),
    .count_o    (peak_count_o),
    .noint_o    (no_interval_o)
  );

endmodule

// ----- test/peak_interval_averager_unit_test.sv -----
`timescale 1ns / 100ps

module peak_interval_averager_unit_test;
  import pia_pkg::*;

  // Geometry and limits of the block at its default parameters.
  localparam int unsigned SPAN         = 2;
  localparam int unsigned WINDOW_DEPTH = 2 * SPAN;
  localparam int unsigned SEQ_LIMIT    = 65535;
  localparam logic [SAMPLE_W-1:0] AMP_MAX = '1;
  // Trailing judgement plus the serial divide, with room to spare.
  localparam int unsigned SETTLE_CYCLES = 48;
  // Longest legal stretch without any word moving is well under this.
  localparam int unsigned STALL_LIMIT   = 5000;
  localparam int unsigned RANDOM_WORDS  = 1800;

  typedef struct packed {
    logic [SAMPLE_W-1:0] mean;
    logic [COUNT_W-1:0]  peaks;
    logic                none;
  } interval_result_t;

  typedef logic [SAMPLE_W-1:0] amp_list_t[$];

  logic                clk_i;
  logic                rst_ni        = 1'b0;
  logic                push          = 1'b0;
  logic                full;
  logic [SAMPLE_W-1:0] amplitude_i   = '0;
  logic                last_sample_i = 1'b0;
  logic                empty;
  logic                pop           = 1'b0;
  logic [SAMPLE_W-1:0] mean_interval_o;
  logic [COUNT_W-1:0]  peak_count_o;
  logic                no_interval_o;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [SAMPLE_W-1:0] cfg_data_i    = '0;

  peak_interval_averager_unit DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .amplitude_i    (amplitude_i),
    .last_sample_i  (last_sample_i),
    .empty          (empty),
    .pop            (pop),
    .mean_interval_o(mean_interval_o),
    .peak_count_o   (peak_count_o),
    .no_interval_o  (no_interval_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Shadow copy of the peak tracker: margin register, the last few samples
  // (entry 0 newest), position in the sequence and the gap statistics.
  logic [SAMPLE_W-1:0] margin_shadow;
  logic [SAMPLE_W-1:0] recent_amp [WINDOW_DEPTH];
  int unsigned         seq_index;
  int unsigned         last_peak_index;
  bit                  peak_seen;
  int unsigned         gap_sum;
  int unsigned         gap_count;
  int unsigned         peak_total;

  interval_result_t results_due[$];

  // Run bookkeeping.
  bit          calm;
  int unsigned mismatch_count;
  int unsigned words_sent;
  int unsigned sequences_sent;
  int unsigned results_checked;
  int unsigned margin_writes;
  int unsigned stall_cycles;
  int unsigned pop_rest;

  function automatic void clear_tracker();
    foreach (recent_amp[i]) recent_amp[i] = '0;
    seq_index       = 0;
    last_peak_index = 0;
    peak_seen       = 1'b0;
    gap_sum         = 0;
    gap_count       = 0;
    peak_total      = 0;
  endfunction

  // Amplitude at absolute position idx while position n (value cur) is arriving.
  function automatic logic [SAMPLE_W-1:0] amp_at(int unsigned idx, int unsigned n,
                                                 logic [SAMPLE_W-1:0] cur);
    int unsigned d;
    if (idx == n) return cur;
    d = n - 1 - idx;
    if (d < WINDOW_DEPTH) return recent_amp[d];
    return '0;
  endfunction

  // A candidate must beat every neighbour inside the sequence by more than the
  // margin; the sum is held one bit wider so it never wraps.
  function automatic bit is_local_max(int unsigned c, int unsigned n,
                                      logic [SAMPLE_W-1:0] cur);
    logic [SAMPLE_W:0] v;
    bit                ok;
    ok = 1'b1;
    v  = {1'b0, amp_at(c, n, cur)};
    for (int unsigned k = 1; k <= SPAN; k++) begin
      if (c >= k && !(v > {1'b0, amp_at(c - k, n, cur)} + {1'b0, margin_shadow})) ok = 1'b0;
      if (c + k <= n && !(v > {1'b0, amp_at(c + k, n, cur)} + {1'b0, margin_shadow})) ok = 1'b0;
    end
    return ok;
  endfunction

  function automatic void score_candidate(int unsigned c, int unsigned n,
                                          logic [SAMPLE_W-1:0] cur);
    if (!is_local_max(c, n, cur)) return;
    if (peak_seen) begin
      gap_sum   += c - last_peak_index;
      gap_count += 1;
    end
    last_peak_index = c;
    peak_seen       = 1'b1;
    if (peak_total < 65535) peak_total++;
  endfunction

  // Advance the shadow tracker by one accepted word and queue the interval
  // result when the sequence closes (flagged, or forced at the length limit).
  function automatic void track_word(logic [SAMPLE_W-1:0] amp, bit last);
    int unsigned      n;
    int unsigned      first;
    bit               at_end;
    longint unsigned  mean;
    interval_result_t res;
    n      = seq_index;
    at_end = last || (n + 1 >= SEQ_LIMIT);
    if (n >= SPAN) score_candidate(n - SPAN, n, amp);
    if (!at_end) begin
      for (int i = WINDOW_DEPTH - 1; i > 0; i--) recent_amp[i] = recent_amp[i-1];
      recent_amp[0] = amp;
      seq_index     = n + 1;
      return;
    end
    // Judge the trailing candidates; their missing right neighbours pass.
    first = (n >= SPAN) ? n - SPAN + 1 : 0;
    for (int unsigned c = first; c <= n; c++) score_candidate(c, n, amp);
    if (gap_count == 0) mean = (longint'(n) + 1) << 8;
    else mean = (longint'(gap_sum) << 8) / gap_count;
    if (mean > AMP_MAX) mean = AMP_MAX;
    res.mean  = mean[SAMPLE_W-1:0];
    res.peaks = peak_total[COUNT_W-1:0];
    res.none  = (gap_count == 0);
    results_due.push_back(res);
    clear_tracker();
  endfunction

  function automatic logic [SAMPLE_W-1:0] clamp_amp(longint unsigned v);
    return (v > AMP_MAX) ? AMP_MAX : v[SAMPLE_W-1:0];
  endfunction

  // Offer one word, with an occasional idle burst ahead of it, and hold it
  // until the block takes it. Push stays high for a following word.
  task automatic send_word(input logic [SAMPLE_W-1:0] amp, input bit last);
    int unsigned gap;
    if (!calm && $urandom_range(0, 9) == 0) begin
      gap  = $urandom_range(1, 9);
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push          <= 1'b1;
    amplitude_i   <= amp;
    last_sample_i <= last;
    do @(posedge clk_i); while (full);
    track_word(amp, last);
    words_sent++;
  endtask

  task automatic send_sequence(input amp_list_t amps);
    foreach (amps[i]) send_word(amps[i], i == amps.size() - 1);
    sequences_sent++;
  endtask

  // Drop push and hold until every queued result has been popped.
  task automatic wait_results();
    push <= 1'b0;
    do @(posedge clk_i); while (results_due.size() != 0);
  endtask

  // Write the margin register only once the block has gone quiet.
  task automatic write_margin(input logic [SAMPLE_W-1:0] value);
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i   <= 1'b0;
    margin_shadow  = value;
    margin_writes++;
  endtask

  // Random sequence: mostly short, now and then long. Styles: a narrow band
  // around a random level, full-scale noise, or a low floor with spikes
  // that clear the margin at a random spacing (close spacings break them).
  task automatic build_sequence(output amp_list_t amps);
    int unsigned     len;
    int unsigned     r;
    int unsigned     style;
    int unsigned     spacing;
    int unsigned     offset;
    longint unsigned base;
    longint unsigned spread;
    longint unsigned v;
    amps  = {};
    r     = $urandom_range(0, 19);
    len   = (r < 13) ? $urandom_range(1, 12) : (r < 19) ? $urandom_range(13, 60)
                                                       : $urandom_range(61, 200);
    style   = $urandom_range(0, 3);
    base    = $urandom_range(0, AMP_MAX);
    spread  = longint'(1) << $urandom_range(0, 10);
    spacing = $urandom_range(1, 8);
    offset  = $urandom_range(0, spacing - 1);
    for (int unsigned i = 0; i < len; i++) begin
      case (style)
        0: v = base + $urandom_range(0, spread);
        1: v = $urandom_range(0, AMP_MAX);
        default: begin
          v = $urandom_range(0, 15);
          if (i % spacing == offset) v += 16 + margin_shadow + $urandom_range(0, 40);
        end
      endcase
      amps.push_back(clamp_amp(v));
    end
  endtask

  task automatic check_field(input string label, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d actual %0d", $time, label, want, got);
      mismatch_count++;
    end
  endtask

  // Pop side: check each popped word against the oldest expectation, then
  // choose the next pop level, stalling now and then in random bursts.
  always @(posedge clk_i) begin : result_check
    interval_result_t want;
    if (rst_ni) begin
      if (pop && !empty) begin
        if (results_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual mean %0d peaks %0d none %0d",
                   $time, mean_interval_o, peak_count_o, no_interval_o);
          mismatch_count++;
        end else begin
          want = results_due.pop_front();
          check_field("mean_interval", want.mean, mean_interval_o);
          check_field("peak_count", want.peaks, peak_count_o);
          check_field("no_interval", want.none, no_interval_o);
          results_checked++;
        end
      end
      if (calm) begin
        pop <= 1'b1;
      end else if (pop_rest > 0) begin
        pop_rest--;
        pop <= 1'b0;
      end else if ($urandom_range(0, 9) == 0) begin
        pop_rest = $urandom_range(0, 8);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when no word moves on any channel for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, stall_cycles);
      $display("end of test: mismatches");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Reset margin of zero: single samples, short edges, flat runs, two peaks
  // with a known gap, and alternating bit patterns.
  task automatic test_reset_margin();
    send_sequence('{24'h000000});
    send_sequence('{AMP_MAX});
    send_sequence('{AMP_MAX, 24'h000000});
    send_sequence('{24'h000000, AMP_MAX, 24'h000000});
    send_sequence('{24'd5, 24'd5, 24'd5});
    send_sequence('{24'd9, 24'd1, 24'd2, 24'd1, 24'd9, 24'd0, 24'd0});
    send_sequence('{24'hAAAAAA, 24'h555555, 24'hAAAAAA, 24'h555555, 24'hAAAAAA});
  endtask

  // Margin edges: exactly equal to the step fails, one less passes, full
  // scale leaves only the neighbourless single sample as a peak.
  task automatic test_margin_edges();
    write_margin(24'd10);
    send_sequence('{24'd10, 24'd0});
    write_margin(24'd9);
    send_sequence('{24'd10, 24'd0});
    write_margin(AMP_MAX);
    send_sequence('{AMP_MAX, 24'd0, 24'd0});
    send_sequence('{24'd7});
  endtask

  task automatic test_random_sequences();
    int unsigned         target;
    int unsigned         phase_words;
    bit                  paused;
    logic [SAMPLE_W-1:0] m;
    amp_list_t           amps;
    target = words_sent + RANDOM_WORDS;
    paused = 1'b0;
    while (words_sent < target) begin
      case ($urandom_range(0, 5))
        0: m = '0;
        1: m = AMP_MAX;
        2: m = $urandom_range(0, 8);
        3: m = $urandom_range(0, 255);
        4: m = $urandom_range(0, AMP_MAX);
        default: m = 24'd1 << $urandom_range(0, SAMPLE_W - 1);
      endcase
      write_margin(m);
      phase_words = 0;
      while (phase_words < 150 && words_sent < target) begin
        build_sequence(amps);
        send_sequence(amps);
        phase_words += amps.size();
        // Once, let the result side run dry before sending on.
        if (!paused && phase_words > 60) begin
          wait_results();
          paused = 1'b1;
        end
      end
    end
  endtask

  // Closing stretch with no idling on either side.
  task automatic test_back_to_back();
    amp_list_t amps;
    write_margin($urandom_range(0, 20));
    calm = 1'b1;
    repeat (12) begin
      build_sequence(amps);
      if (amps.size() > 20) amps = amps[0:19];
      send_sequence(amps);
    end
  endtask

  initial begin
    calm          = 1'b0;
    margin_shadow = '0;
    clear_tracker();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_margin();
    test_margin_edges();
    test_random_sequences();
    test_back_to_back();

    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("covered %0d words in %0d sequences, %0d results checked",
             words_sent, sequences_sent, results_checked);
    $display("margin written %0d times, zero and full scale included, idle bursts both sides",
             margin_writes);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
